[hdl/lrta_pkg.sv]
// ----------------------------------------------------------------------------
// lrta_pkg
// Shared constants, types and functions of the lidar ring and time block.
// ----------------------------------------------------------------------------
package lrta_pkg;

    localparam int COORD_WIDTH_DEF = 24;
    localparam int CORDIC_ITER_DEF = 16;
    localparam int FIFO_DEPTH      = 2;

    // Coordinates are scaled by 2^8 before the CORDIC runs.
    localparam int GUARD_BITS = 8;
    // Angle accumulator in units of 2^-20 rad.
    localparam int ANGLE_W    = 25;
    localparam int TIME_W     = 20;

    localparam logic [19:0] INV_GAIN_Q20    = 20'd636751;
    localparam logic [22:0] DEG_PER_RAD_Q16 = 23'd3754936;
    localparam int          ATAN_ONE_X4     = 3294200;

    localparam int A_PI            = 51472;
    localparam int A_HALF_PI       = 25736;
    localparam int A_THREE_HALF_PI = 77208;
    localparam int A_TWO_PI        = 102944;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_LINE_MODE = 2'd0;
    localparam logic [1:0] REG_START_ORI = 2'd1;
    localparam logic [1:0] REG_END_ORI   = 2'd2;
    localparam logic [1:0] REG_PERIOD    = 2'd3;

    // Line modes.
    localparam logic [1:0] LM_16 = 2'd0;
    localparam logic [1:0] LM_32 = 2'd1;
    localparam logic [1:0] LM_64 = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [5:0] ring;
    } ring_res_t;

    function automatic logic [19:0] atan_entry(input logic [4:0] idx);
        logic [19:0] v;
        unique case (idx)
            5'd0:    v = 20'd823550;
            5'd1:    v = 20'd486170;
            5'd2:    v = 20'd256879;
            5'd3:    v = 20'd130396;
            5'd4:    v = 20'd65451;
            5'd5:    v = 20'd32757;
            5'd6:    v = 20'd16383;
            5'd7:    v = 20'd8192;
            5'd8:    v = 20'd4096;
            5'd9:    v = 20'd2048;
            5'd10:   v = 20'd1024;
            5'd11:   v = 20'd512;
            5'd12:   v = 20'd256;
            5'd13:   v = 20'd128;
            5'd14:   v = 20'd64;
            5'd15:   v = 20'd32;
            5'd16:   v = 20'd16;
            5'd17:   v = 20'd8;
            5'd18:   v = 20'd4;
            5'd19:   v = 20'd2;
            5'd20:   v = 20'd1;
            default: v = 20'd0;
        endcase
        return v;
    endfunction

    // Division by 2^k that truncates toward zero.
    function automatic logic signed [31:0] trunc_shr(input logic signed [31:0] n,
                                                     input int k);
        logic signed [31:0] r;
        if (n[31])
            r = -((-n) >>> k);
        else
            r = n >>> k;
        return r;
    endfunction

    function automatic ring_res_t ring_calc(input logic [1:0] mode,
                                            input logic signed [31:0] d);
        ring_res_t r;
        logic signed [31:0] id;
        r.ok = 1'b0;
        id = 32'sd0;
        unique case (mode)
            LM_16:
            begin
                id = trunc_shr(d + 32'sd1048576, 17);
                r.ok = (id >= 32'sd0) && (id <= 32'sd15);
            end
            LM_32:
            begin
                id = trunc_shr(32'sd3 * d + 32'sd6029312, 18);
                r.ok = (id >= 32'sd0) && (id <= 32'sd31);
            end
            LM_64:
            begin
                if (d >= -32'sd578683)
                    id = trunc_shr(32'sd425984 - 32'sd3 * d, 16);
                else
                    id = 32'sd32 + ((32'sd2 * (-32'sd578683 - d) + 32'sd32768) >>> 16);
                r.ok = !((d > 32'sd131072) || (d < -32'sd1594491) ||
                         (id > 32'sd50) || (id < 32'sd0));
            end
            default:
            begin
                id = 32'sd0;
                r.ok = 1'b0;
            end
        endcase
        r.ring = id[5:0];
        return r;
    endfunction

endpackage

[hdl/lrta_fifo.sv]
// ----------------------------------------------------------------------------
// lrta_fifo
// Short request queue between the input side and the processing sequencer.
// ----------------------------------------------------------------------------
module lrta_fifo
    import lrta_pkg::*;
#(
    parameter int WIDTH = 90,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign in_ready  = (cnt_reg != CNT_FULL);
    assign out_valid = (cnt_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_data;
    end

endmodule

[hdl/lrta_cordic.sv]
// ----------------------------------------------------------------------------
// lrta_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
module lrta_cordic
    import lrta_pkg::*;
#(
    parameter int WIDTH      = 35,
    parameter int ITERATIONS = CORDIC_ITER_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic signed [WIDTH-1:0]   x_in,
    input  logic signed [WIDTH-1:0]   y_in,
    output logic                      done,
    output logic signed [ANGLE_W-1:0] angle,
    output logic signed [WIDTH-1:0]   mag
);

    localparam int CNT_W = $clog2(ITERATIONS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ITERATIONS - 1);

    logic signed [WIDTH-1:0]   x_reg, y_reg, xs, ys;
    logic signed [ANGLE_W-1:0] acc_reg, step;
    logic [CNT_W-1:0]          cnt_reg;
    logic                      run_reg, done_reg;
    logic                      zero_in;

    assign zero_in = (x_in == '0) && (y_in == '0);
    assign xs      = x_reg >>> cnt_reg;
    assign ys      = y_reg >>> cnt_reg;
    assign step    = ANGLE_W'(atan_entry(5'(cnt_reg)));
    assign done    = done_reg;
    assign angle   = acc_reg;
    assign mag     = x_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg  <= '0;
                // A point at the origin needs no rotation: angle and magnitude are zero.
                run_reg  <= !zero_in;
                done_reg <= zero_in;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= x_in;
            y_reg   <= y_in;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            if (!y_reg[WIDTH-1])
            begin
                x_reg   <= x_reg + ys;
                y_reg   <= y_reg - xs;
                acc_reg <= acc_reg + step;
            end
            else
            begin
                x_reg   <= x_reg - ys;
                y_reg   <= y_reg + xs;
                acc_reg <= acc_reg - step;
            end
        end
    end

endmodule

[hdl/lrta_core.sv]
// ----------------------------------------------------------------------------
// lrta_core
// Processing sequencer: angles, ring rule, orientation unwrap, time division.
// ----------------------------------------------------------------------------
module lrta_core
    import lrta_pkg::*;
#(
    parameter int COORD_WIDTH       = COORD_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic signed [COORD_WIDTH-1:0] item_x,
    input  logic signed [COORD_WIDTH-1:0] item_y,
    input  logic signed [COORD_WIDTH-1:0] item_z,
    input  logic [15:0]                   item_intensity,
    input  logic                          item_frame_start,
    input  logic [1:0]                    line_mode,
    input  logic [16:0]                   start_ori,
    input  logic [17:0]                   end_ori,
    input  logic [TIME_W-1:0]             scan_period,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_x_mm,
    output logic signed [COORD_WIDTH-1:0] out_y_mm,
    output logic signed [COORD_WIDTH-1:0] out_z_mm,
    output logic [15:0]                   out_intensity,
    output logic [5:0]                    ring,
    output logic [TIME_W-1:0]             time_offset_us,
    output logic                          point_valid
);

    localparam int GW  = COORD_WIDTH + GUARD_BITS + 3;
    localparam int PW  = GW - 1 + 20;
    localparam int DPW = ANGLE_W + 24;
    localparam int OW  = 24;
    localparam int NW  = 19;
    localparam int DW  = TIME_W + NW + 1;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CORD1  = 4'd1;
    localparam logic [3:0] S_HMUL   = 4'd2;
    localparam logic [3:0] S_HYP    = 4'd3;
    localparam logic [3:0] S_C2GO   = 4'd4;
    localparam logic [3:0] S_CORD2  = 4'd5;
    localparam logic [3:0] S_DEG    = 4'd6;
    localparam logic [3:0] S_RING   = 4'd7;
    localparam logic [3:0] S_UNWRAP = 4'd8;
    localparam logic [3:0] S_DMUL   = 4'd9;
    localparam logic [3:0] S_DIV    = 4'd10;
    localparam logic [3:0] S_OUT    = 4'd11;

    localparam logic signed [OW-1:0] C_PI      = OW'(A_PI);
    localparam logic signed [OW-1:0] C_HALF    = OW'(A_HALF_PI);
    localparam logic signed [OW-1:0] C_3HALF   = OW'(A_THREE_HALF_PI);
    localparam logic signed [OW-1:0] C_TWO     = OW'(A_TWO_PI);
    localparam logic signed [ANGLE_W-1:0] C_HALF_TURN = ANGLE_W'(ATAN_ONE_X4);
    localparam logic [4:0]           DIV_LAST  = 5'(TIME_W - 1);

    logic [3:0] state_reg, state_next;

    logic signed [COORD_WIDTH-1:0] x_reg, y_reg, z_reg;
    logic [15:0]                   int_reg;
    logic                          neg_reg, ypos_reg;
    logic signed [GW-1:0]          gz_reg, mag_reg, h_reg;
    logic signed [ANGLE_W-1:0]     ha_reg;
    logic [PW-1:0]                 hprod_reg;
    logic signed [DPW-1:0]         dprod_reg;
    logic signed [31:0]            deg_reg;
    logic                          ok_reg;
    logic [5:0]                    ring_reg;
    logic                          half_passed_reg;
    logic [NW-1:0]                 num_reg, den_reg;
    logic [DW-1:0]                 rem_reg;
    logic [TIME_W-1:0]             q_reg;
    logic [4:0]                    div_cnt_reg;

    logic                          out_valid_reg;
    logic signed [COORD_WIDTH-1:0] ox_reg, oy_reg, oz_reg;
    logic [15:0]                   oint_reg;
    logic [5:0]                    oring_reg;
    logic [TIME_W-1:0]             otime_reg;
    logic                          opv_reg;

    logic signed [GW-1:0]          gx, gy, gz;
    logic signed [GW-1:0]          c_x, c_y;
    logic                          c_start, c_done;
    logic signed [ANGLE_W-1:0]     c_angle;
    logic signed [GW-1:0]          c_mag;
    logic                          take, out_load;

    logic [PW-1:0]                 hsum;
    logic signed [DPW-1:0]         dsum;
    ring_res_t                     rr;

    logic signed [ANGLE_W:0]       ha_r;
    logic signed [OW-1:0]          ori0, ori1, s_ext, e_ext, num, den;
    logic                          hp_set;

    logic [DW-1:0]                 den_sh;
    logic                          q_bit;

    assign gx = {{3{item_x[COORD_WIDTH-1]}}, item_x, {GUARD_BITS{1'b0}}};
    assign gy = {{3{item_y[COORD_WIDTH-1]}}, item_y, {GUARD_BITS{1'b0}}};
    assign gz = {{3{item_z[COORD_WIDTH-1]}}, item_z, {GUARD_BITS{1'b0}}};

    assign item_ready = (state_reg == S_IDLE);
    assign take       = item_valid && item_ready;
    assign c_start    = take || (state_reg == S_C2GO);

    // The first run folds left-half points into the right half plane.
    assign c_x = (state_reg == S_IDLE) ? (gx[GW-1] ? -gx : gx) : h_reg;
    assign c_y = (state_reg == S_IDLE) ? (gx[GW-1] ? -gy : gy) : gz_reg;

    lrta_cordic #(
        .WIDTH      (GW),
        .ITERATIONS (CORDIC_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (c_start),
        .x_in  (c_x),
        .y_in  (c_y),
        .done  (c_done),
        .angle (c_angle),
        .mag   (c_mag)
    );

    assign hsum = hprod_reg + PW'(524288);
    assign dsum = dprod_reg + DPW'(524288);
    assign rr   = ring_calc(line_mode, deg_reg);

    // Horizontal orientation, unwrapped against the frame's start and end.
    always_comb
    begin
        ha_r  = {ha_reg[ANGLE_W-1], ha_reg} + (ANGLE_W+1)'(32);
        ori0  = -(OW'(ha_r >>> 6));
        s_ext = OW'($signed(start_ori));
        e_ext = OW'($signed({1'b0, end_ori}));
        ori1  = ori0;
        hp_set = 1'b0;
        if (!half_passed_reg)
        begin
            if (ori0 < s_ext - C_HALF)
                ori1 = ori0 + C_TWO;
            else if (ori0 > s_ext + C_3HALF)
                ori1 = ori0 - C_TWO;
            hp_set = (ori1 - s_ext) > C_PI;
        end
        else
        begin
            ori1 = ori0 + C_TWO;
            if (ori1 < e_ext - C_3HALF)
                ori1 = ori1 + C_TWO;
            else if (ori1 > e_ext + C_HALF)
                ori1 = ori1 - C_TWO;
        end
        num = ori1 - s_ext;
        den = e_ext - s_ext;
    end

    assign den_sh = DW'(den_reg) << (DIV_LAST - div_cnt_reg);
    assign q_bit  = (rem_reg >= den_sh);

    assign out_load = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (take) state_next = S_CORD1;
            S_CORD1:  if (c_done) state_next = S_HMUL;
            S_HMUL:   state_next = S_HYP;
            S_HYP:    state_next = S_C2GO;
            S_C2GO:   state_next = S_CORD2;
            S_CORD2:  if (c_done) state_next = S_DEG;
            S_DEG:    state_next = S_RING;
            S_RING:   state_next = rr.ok ? S_UNWRAP : S_OUT;
            S_UNWRAP:
            begin
                if (den <= 0 || num <= 0 || num >= den)
                    state_next = S_OUT;
                else
                    state_next = S_DMUL;
            end
            S_DMUL:   state_next = S_DIV;
            S_DIV:    if (div_cnt_reg == DIV_LAST) state_next = S_OUT;
            S_OUT:    if (out_load) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            half_passed_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (take && item_frame_start)
                half_passed_reg <= 1'b0;
            else if (state_reg == S_UNWRAP && hp_set)
                half_passed_reg <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg    <= item_x;
            y_reg    <= item_y;
            z_reg    <= item_z;
            int_reg  <= item_intensity;
            neg_reg  <= gx[GW-1];
            ypos_reg <= !gy[GW-1];
            gz_reg   <= gz;
        end
        if (state_reg == S_CORD1 && c_done)
        begin
            mag_reg <= c_mag;
            if (neg_reg)
                ha_reg <= ypos_reg ? c_angle + C_HALF_TURN : c_angle - C_HALF_TURN;
            else
                ha_reg <= c_angle;
        end
        if (state_reg == S_HMUL)
            hprod_reg <= PW'(mag_reg[GW-2:0]) * PW'(INV_GAIN_Q20);
        if (state_reg == S_HYP)
            h_reg <= $signed({1'b0, hsum[PW-1:20]});
        if (state_reg == S_CORD2 && c_done)
            dprod_reg <= DPW'(c_angle) * DPW'($signed({1'b0, DEG_PER_RAD_Q16}));
        if (state_reg == S_DEG)
            deg_reg <= 32'(dsum >>> 20);
        if (state_reg == S_RING)
        begin
            ok_reg   <= rr.ok;
            ring_reg <= rr.ring;
            q_reg    <= '0;
        end
        if (state_reg == S_UNWRAP)
        begin
            num_reg <= num[NW-1:0];
            den_reg <= den[NW-1:0];
            if (den <= 0 || num <= 0)
                q_reg <= '0;
            else if (num >= den)
                q_reg <= scan_period;
        end
        if (state_reg == S_DMUL)
        begin
            rem_reg     <= DW'(scan_period) * DW'(num_reg) + DW'(den_reg >> 1);
            div_cnt_reg <= '0;
        end
        if (state_reg == S_DIV)
        begin
            if (q_bit)
                rem_reg <= rem_reg - den_sh;
            q_reg       <= {q_reg[TIME_W-2:0], q_bit};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (out_load)
        begin
            ox_reg    <= ok_reg ? x_reg : '0;
            oy_reg    <= ok_reg ? y_reg : '0;
            oz_reg    <= ok_reg ? z_reg : '0;
            oint_reg  <= ok_reg ? int_reg : '0;
            oring_reg <= ok_reg ? ring_reg : '0;
            otime_reg <= ok_reg ? q_reg : '0;
            opv_reg   <= ok_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_x_mm       = ox_reg;
    assign out_y_mm       = oy_reg;
    assign out_z_mm       = oz_reg;
    assign out_intensity  = oint_reg;
    assign ring           = oring_reg;
    assign time_offset_us = otime_reg;
    assign point_valid    = opv_reg;

endmodule

[hdl/lidar_ring_and_time_assign_top.sv]
// ----------------------------------------------------------------------------
// lidar_ring_and_time_assign_top
// Assigns a ring number and a time offset in the sweep to each lidar point.
// ----------------------------------------------------------------------------
// Points enter on the in_valid/in_ready channel, one request per point, and
// land in a two-entry queue. A sequencer takes one point at a time and
// delivers one result per point on the out_valid/out_ready channel; a result
// with point_valid low carries zeros in every field.
// Per point the sequencer uses two runs of one shared CORDIC unit, nine
// multiply, rounding and control steps, and a 20-step restoring divider.
// Points that fail the ring rule or fall outside the frame span skip the
// divider. When the sequencer is idle, the queue hands a point over in the
// cycle after it arrives.
// Start and end orientation, line mode and scan period are to be written on
// the APB port between frames; the block itself does not enforce this.
// Reset clears the queue, the half-passed flag and the output valid flag,
// and loads the register defaults. While out_ready is low the finished
// result waits in the output register, the sequencer holds the next result,
// and the queue keeps taking points until it is full.
// ----------------------------------------------------------------------------
module lidar_ring_and_time_assign_top
    import lrta_pkg::*;
#(
    parameter int COORD_WIDTH       = COORD_WIDTH_DEF,
    parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [3:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] x_mm,
    input  logic signed [COORD_WIDTH-1:0] y_mm,
    input  logic signed [COORD_WIDTH-1:0] z_mm,
    input  logic [15:0]                   intensity,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] out_x_mm,
    output logic signed [COORD_WIDTH-1:0] out_y_mm,
    output logic signed [COORD_WIDTH-1:0] out_z_mm,
    output logic [15:0]                   out_intensity,
    output logic [5:0]                    ring,
    output logic [TIME_W-1:0]             time_offset_us,
    output logic                          point_valid
);

    localparam int ITEM_W = 3 * COORD_WIDTH + 17;

    logic [1:0]        line_mode_reg;
    logic [16:0]       start_ori_reg;
    logic [17:0]       end_ori_reg;
    logic [TIME_W-1:0] period_reg;
    logic              wr_en;

    logic [ITEM_W-1:0] q_in, q_out;
    logic              q_valid, q_ready;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_mode_reg <= LM_16;
            start_ori_reg <= '0;
            end_ori_reg   <= 18'(A_TWO_PI);
            period_reg    <= 20'd100000;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_LINE_MODE: line_mode_reg <= pwdata[1:0];
                REG_START_ORI: start_ori_reg <= pwdata[16:0];
                REG_END_ORI:   end_ori_reg   <= pwdata[17:0];
                REG_PERIOD:    period_reg    <= pwdata[TIME_W-1:0];
                default:       line_mode_reg <= line_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LINE_MODE: prdata = 32'(line_mode_reg);
            REG_START_ORI: prdata = 32'(start_ori_reg);
            REG_END_ORI:   prdata = 32'(end_ori_reg);
            REG_PERIOD:    prdata = 32'(period_reg);
            default:       prdata = '0;
        endcase
    end

    assign q_in = {x_mm, y_mm, z_mm, intensity, frame_start};

    lrta_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (q_in),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_out)
    );

    lrta_core #(
        .COORD_WIDTH       (COORD_WIDTH),
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (q_valid),
        .item_ready       (q_ready),
        .item_x           ($signed(q_out[ITEM_W-1 -: COORD_WIDTH])),
        .item_y           ($signed(q_out[ITEM_W-1-COORD_WIDTH -: COORD_WIDTH])),
        .item_z           ($signed(q_out[16+COORD_WIDTH -: COORD_WIDTH])),
        .item_intensity   (q_out[16:1]),
        .item_frame_start (q_out[0]),
        .line_mode        (line_mode_reg),
        .start_ori        (start_ori_reg),
        .end_ori          (end_ori_reg),
        .scan_period      (period_reg),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_x_mm         (out_x_mm),
        .out_y_mm         (out_y_mm),
        .out_z_mm         (out_z_mm),
        .out_intensity    (out_intensity),
        .ring             (ring),
        .time_offset_us   (time_offset_us),
        .point_valid      (point_valid)
    );

endmodule

[hdl/lrta_checker.sv]
// ----------------------------------------------------------------------------
// lrta_checker
// Port-level checks of the lidar ring and time block, bound to the top level.
// ----------------------------------------------------------------------------
module lrta_checker
    import lrta_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          psel,
    input logic                          penable,
    input logic                          pwrite,
    input logic [3:0]                    paddr,
    input logic [31:0]                   pwdata,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic signed [COORD_WIDTH-1:0] out_x_mm,
    input logic [5:0]                    ring,
    input logic [TIME_W-1:0]             time_offset_us,
    input logic                          point_valid
);

    logic [TIME_W-1:0] period_reg;

    // Shadow of the scan period, tracked from register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            period_reg <= 20'd100000;
        else if (psel && penable && pwrite && paddr[3:2] == REG_PERIOD)
            period_reg <= pwdata[TIME_W-1:0];
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> ring == '0 && out_x_mm == '0 && time_offset_us == '0)
        else $error("invalid point carries nonzero fields");

    a_time_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> time_offset_us <= period_reg)
        else $error("time offset beyond scan period");

    a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> ring <= 6'd50)
        else $error("ring number beyond any line rule");

endmodule

bind lidar_ring_and_time_assign_top lrta_checker #(
    .COORD_WIDTH (COORD_WIDTH)
) u_lrta_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_x_mm       (out_x_mm),
    .ring           (ring),
    .time_offset_us (time_offset_us),
    .point_valid    (point_valid)
);
